/* rtl/b64e_pkg.sv */
// Package for the Base64 stream encoder.
// Holds the job record passed from front to back, character codes and the
// sextet-to-ASCII mapping. No dependencies.
package b64e_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [6:0] CHAR_UPPER_A = 7'h41;
   localparam logic [6:0] CHAR_PLUS    = 7'h2B;
   localparam logic [6:0] CHAR_SLASH   = 7'h2F;
   localparam logic [6:0] CHAR_PAD     = 7'h3D;

   typedef enum logic [1:0] {
      PHASE_FIRST  = 2'd0,
      PHASE_SECOND = 2'd1,
      PHASE_THIRD  = 2'd2
   } phase_type;

   // One accepted byte turns into 1 to 4 characters; last applies to the
   // final character of the job only.
   typedef struct packed {
      logic [3:0][6:0] chars;
      logic [1:0]      num_m1;
      logic            last;
   } job_type;

   // Status of the job queue as seen by the front and the back.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [6:0] sextet_char(input logic [5:0] v);
      logic [6:0] wide;
      logic [6:0] ch;
      wide = {1'b0, v};
      priority if (v < 6'd26) begin
         ch = CHAR_UPPER_A + wide;
      end else if (v < 6'd52) begin
         ch = wide + 7'd71;          // 'a' is 97, 26 places in
      end else if (v < 6'd62) begin
         ch = wide - 7'd4;           // '0' is 48, 52 places in
      end else if (v == 6'd62) begin
         ch = CHAR_PLUS;
      end else begin
         ch = CHAR_SLASH;
      end
      return ch;
   endfunction

endpackage

/* rtl/b64e_front.sv */
// Front of the Base64 encoder: accepts bytes, tracks the 3-byte group and
// builds the character job for each byte. Depends on b64e_pkg.
module b64e_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_data_byte,
   input  logic                       req_end_of_message,
   input  b64e_pkg::queue_status_type q_status,
   output logic                       push,
   output b64e_pkg::job_type          push_job
);

   b64e_pkg::phase_type phase_ff, phase_in;
   logic [3:0]          carry_ff, carry_in;
   logic [1:0][5:0]     sx;
   logic                accept;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign push      = accept;

   always_comb begin
      phase_in        = phase_ff;
      carry_in        = carry_ff;
      sx              = '0;
      push_job.num_m1 = 2'd0;
      push_job.last   = 1'b0;
      unique case (phase_ff)
         b64e_pkg::PHASE_SECOND: begin
            sx[0] = {carry_ff[1:0], req_data_byte[7:4]};
            sx[1] = {req_data_byte[3:0], 2'b00};
            if (req_end_of_message) begin
               push_job.num_m1 = 2'd2;
               push_job.last   = 1'b1;
               phase_in        = b64e_pkg::PHASE_FIRST;
               carry_in        = 4'd0;
            end else begin
               phase_in = b64e_pkg::PHASE_THIRD;
               carry_in = req_data_byte[3:0];
            end
         end
         b64e_pkg::PHASE_THIRD: begin
            sx[0]           = {carry_ff, req_data_byte[7:6]};
            sx[1]           = req_data_byte[5:0];
            push_job.num_m1 = 2'd1;
            push_job.last   = req_end_of_message;
            phase_in        = b64e_pkg::PHASE_FIRST;
            carry_in        = 4'd0;
         end
         default: begin
            // first byte of a group; an unreachable phase code acts the same
            sx[0] = req_data_byte[7:2];
            sx[1] = {req_data_byte[1:0], 4'b0000};
            if (req_end_of_message) begin
               push_job.num_m1 = 2'd3;
               push_job.last   = 1'b1;
               phase_in        = b64e_pkg::PHASE_FIRST;
               carry_in        = 4'd0;
            end else begin
               phase_in = b64e_pkg::PHASE_SECOND;
               carry_in = {2'b00, req_data_byte[1:0]};
            end
         end
      endcase
      push_job.chars[0] = b64e_pkg::sextet_char(sx[0]);
      push_job.chars[1] = b64e_pkg::sextet_char(sx[1]);
      push_job.chars[2] = b64e_pkg::CHAR_PAD;
      push_job.chars[3] = b64e_pkg::CHAR_PAD;
      if (!accept) begin
         phase_in = phase_ff;
         carry_in = carry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= b64e_pkg::PHASE_FIRST;
         carry_ff <= 4'd0;
      end else begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule

/* rtl/b64e_queue.sv */
// Short job queue between the encoder front and back.
// Register-based FIFO of b64e_pkg::job_type entries. Depends on b64e_pkg.
module b64e_queue #(
   parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  b64e_pkg::job_type          push_job,
   input  logic                       pop,
   output b64e_pkg::job_type          head,
   output b64e_pkg::queue_status_type status
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   b64e_pkg::job_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full && !pop))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty))
      else $error("pop from empty queue");

endmodule

/* rtl/b64e_back.sv */
// Back of the Base64 encoder: walks the head job into the registered result
// channel, one character per cycle while the receiver is ready. Depends on b64e_pkg.
module b64e_back (
   input  logic                       clock,
   input  logic                       reset,
   input  b64e_pkg::job_type          head,
   input  b64e_pkg::queue_status_type q_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [6:0]                 rsp_code_char,
   output logic                       rsp_last_char
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [6:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       load;
   logic       final_char;

   assign final_char = (idx_ff == head.num_m1);
   // output slot is free or is being drained this cycle
   assign load       = !q_status.empty && (!valid_ff || rsp_ready);
   assign pop        = load && final_char;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (load) begin
         idx_in   = final_char ? 2'd0 : idx_ff + 2'd1;
         valid_in = 1'b1;
         char_in  = head.chars[idx_ff];
         last_in  = final_char && head.last;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_code_char = char_ff;
   assign rsp_last_char = last_ff;

   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      !q_status.empty |-> idx_ff <= head.num_m1)
      else $error("character index past end of job");

   a_partial_job_held: assert property (@(posedge clock) disable iff (reset)
      idx_ff != 2'd0 |-> !q_status.empty)
      else $error("partly sent job left the queue");

   a_last_only_at_end: assert property (@(posedge clock) disable iff (reset)
      load && !final_char |=> !last_ff)
      else $error("end flag on inner character");

endmodule

/* rtl/base64_stream_encoder.sv */
// Base64 stream encoder, standard alphabet with '=' padding.
// Top level: front (group tracking), job queue, back (character output).
// Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back.
//
// Usage:
//  - Input channel req_*: one message byte per transfer; req_end_of_message
//    marks the final byte of a message. The next byte starts a new message.
//  - Result channel rsp_*: one ASCII character per transfer. A byte yields
//    1 char (first or second of a group), 2 chars (third of a group), or on
//    a short final group 2 chars plus "=" / "==". rsp_last_char flags the
//    final character of each encoded message.
//  - Path: with the back idle, an accepted byte's job is registered into
//    the queue, and its first character then into the output register,
//    from which it is valid.
//  - Throughput: one character per cycle while the receiver is ready, set
//    by the single output register; 4 characters per 3 bytes on full groups.
//    The front keeps taking bytes while the job queue (QUEUE_DEPTH jobs) has
//    room.
//  - When the receiver stalls, the current character holds in the output
//    register, the queue fills, and req_ready drops once it is full.
//  - Reset (synchronous, active high) empties the queue and output and
//    restarts at the first byte of a group. No clearing pass.
module base64_stream_encoder #(
   parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_message,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_code_char,
   output logic       rsp_last_char
);

   b64e_pkg::queue_status_type q_status;
   b64e_pkg::job_type          push_job;
   b64e_pkg::job_type          head;
   logic                       push;
   logic                       pop;

   b64e_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .q_status           (q_status),
      .push               (push),
      .push_job           (push_job)
   );

   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   b64e_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .q_status      (q_status),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_code_char (rsp_code_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

/* bench/base64_stream_encoder_tb.sv */
// Self-checking bench for base64_stream_encoder: byte messages in, Base64 characters out.
// Queue-fed driver, clocked monitor with an in-bench encoder model and a stall watchdog.
// Depends on b64e_pkg and the encoder RTL.
module base64_stream_encoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int TAIL_CYCLES    = 20;
   localparam int PHASE_BYTES    = 42;
   localparam logic [511:0] B64_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [7:0] data;
      logic       eom;
   } msg_byte_type;

   typedef struct packed {
      logic [6:0] code;
      logic       last;
   } b64_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_end_of_message = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [6:0] rsp_code_char;
   logic       rsp_last_char;

   msg_byte_type pending_bytes[$];
   b64_char_type expected_chars[$];
   int         bytes_queued = 0;
   int         bytes_taken = 0;
   int         error_count = 0;
   int         idle_cycles = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   logic       req_fire = 1'b0;

   // encoder model state
   b64e_pkg::phase_type group_pos = b64e_pkg::PHASE_FIRST;
   logic [3:0] held_bits = 4'h0;

   base64_stream_encoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_code_char      (rsp_code_char),
      .rsp_last_char      (rsp_last_char)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic void push_sextet(input logic [5:0] idx, input logic last);
      b64_char_type c;
      c.code = B64_ALPHABET[8*(63 - idx) +: 7];
      c.last = last;
      expected_chars.push_back(c);
   endfunction

   function automatic void push_pad(input logic last);
      b64_char_type c;
      c.code = b64e_pkg::CHAR_PAD;
      c.last = last;
      expected_chars.push_back(c);
   endfunction

   // Characters completed by one byte; a short final group is zero-filled then padded.
   function automatic void encode_byte(input logic [7:0] b, input logic eom);
      unique case (group_pos)
         b64e_pkg::PHASE_SECOND: begin
            push_sextet({held_bits[1:0], b[7:4]}, 1'b0);
            if (eom) begin
               push_sextet({b[3:0], 2'b00}, 1'b0);
               push_pad(1'b1);
               group_pos = b64e_pkg::PHASE_FIRST;
               held_bits = 4'h0;
            end else begin
               held_bits = b[3:0];
               group_pos = b64e_pkg::PHASE_THIRD;
            end
         end
         b64e_pkg::PHASE_THIRD: begin
            push_sextet({held_bits, b[7:6]}, 1'b0);
            push_sextet(b[5:0], eom);
            group_pos = b64e_pkg::PHASE_FIRST;
            held_bits = 4'h0;
         end
         default: begin
            push_sextet(b[7:2], 1'b0);
            if (eom) begin
               push_sextet({b[1:0], 4'h0}, 1'b0);
               push_pad(1'b0);
               push_pad(1'b1);
               group_pos = b64e_pkg::PHASE_FIRST;
               held_bits = 4'h0;
            end else begin
               held_bits = {2'b00, b[1:0]};
               group_pos = b64e_pkg::PHASE_SECOND;
            end
         end
      endcase
   endfunction

   task automatic queue_byte(input logic [7:0] b, input logic eom);
      msg_byte_type m;
      m.data = b;
      m.eom  = eom;
      pending_bytes.push_back(m);
      bytes_queued++;
   endtask

   task automatic queue_message(input int len);
      for (int i = 0; i < len; i++) begin
         queue_byte(8'($urandom_range(255)), i == len - 1);
      end
   endtask

   // Random messages, mostly short, now and then a long one; some left open.
   task automatic queue_random_phase();
      int target;
      int len;
      target = bytes_queued + PHASE_BYTES;
      while (bytes_queued < target) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(20, 10) : $urandom_range(9, 1);
         if ($urandom_range(7) == 0) begin
            for (int i = 0; i < len; i++) begin
               queue_byte(8'($urandom_range(255)), 1'b0);
            end
         end else begin
            queue_message(len);
         end
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (bytes_taken != bytes_queued || expected_chars.size() != 0) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   // driver: inputs change on the falling edge
   always @(negedge clock) begin : driver
      msg_byte_type m;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_fire) begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               m = pending_bytes.pop_front();
               req_valid          <= 1'b1;
               req_data_byte      <= m.data;
               req_end_of_message <= m.eom;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor: sample on the rising edge, check results, model accepted bytes
   always @(posedge clock) begin : monitor
      b64_char_type want;
      if (reset) begin
         req_fire    <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch("unexpected character", rsp_code_char, 0);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_code_char !== want.code) begin
                  report_mismatch("code_char", rsp_code_char, want.code);
               end
               if (rsp_last_char !== want.last) begin
                  report_mismatch("last_char", rsp_last_char, want.last);
               end
            end
         end
         if (req_valid && req_ready) begin
            encode_byte(req_data_byte, req_end_of_message);
            bytes_taken++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: padding of both lengths, full groups, alphabet ends
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h10, 1'b0);
      queue_byte(8'h83, 1'b1);
      queue_byte(8'hFB, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hBF, 1'b1);
      queue_byte(8'h4D, 1'b0);
      queue_byte(8'h61, 1'b0);
      queue_byte(8'h6E, 1'b1);
      queue_byte(8'h4D, 1'b0);
      queue_byte(8'h61, 1'b0);
      queue_byte(8'h6E, 1'b0);
      queue_byte(8'h79, 1'b1);
      queue_byte(8'hAA, 1'b0);
      queue_byte(8'h55, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hC3, 1'b1);
      queue_random_phase();
      wait_drained();

      send_idle_pct  = 62;
      recv_stall_pct = 0;
      queue_random_phase();
      wait_drained();

      send_idle_pct  = 0;
      recv_stall_pct = 62;
      queue_random_phase();
      wait_drained();

      send_idle_pct  = 29;
      recv_stall_pct = 29;
      queue_random_phase();
      queue_message(3);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_chars.size() != 0) begin
         report_mismatch("characters never delivered", 0, expected_chars.size());
      end
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
